// ===== rtl/rbi_pkg.sv =====
// shared types, constants and helpers for the ray / box intersection block
package rbi_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_BITS    = 32;
  localparam int IN_FIELDS     = 12;
  localparam int OUT_POINTS    = 3;
  localparam int IN_DATA_BITS  = IN_FIELDS * FIELD_BITS;
  localparam int OUT_DATA_BITS = OUT_POINTS * FIELD_BITS;
  localparam int OUT_USER_BITS = 3;
  localparam int EXT_BITS      = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam int MUL_DIGIT     = 32;

  // origin position against the slab of one axis
  typedef struct packed {
    logic below;
    logic above;
  } rbi_side_t;

  typedef enum logic [1:0] {
    PLANE_X      = 2'd0,
    PLANE_Y      = 2'd1,
    PLANE_Z      = 2'd2,
    PLANE_ORIGIN = 2'd3
  } rbi_plane_t;

  // bits of one classified item: per axis four words, numerator, |dir|, side flags
  function automatic int item_bits(input int w);
    return 3 * (6 * w + 2) + 1;
  endfunction

endpackage

// ===== rtl/ray_box_intersection_top.sv =====
// top level of the ray / axis-aligned box intersection block
// usage:
// - in channel: one ray and box per transfer, twelve signed Q16.16 words on in_tdata
// - out channel: one result per input transfer, hit flag and hit plane on out_tuser,
//   entry point x, y, z on out_tdata, all zero on a miss
// - a short fifo parts the classifying front end from the arithmetic back end
// the back end is a pipeline built around a one-bit-per-stage divider
// throughput: one item per cycle when not stalled, results in input order
// stalls: while out_tready is low with a result waiting, the back end freezes,
//   the fifo absorbs up to four items, then in_tready drops
// reset: synchronous active-low rst_n empties the fifo and clears every valid bit;
//   no configuration and no state carry between items
module ray_box_intersection_top #(
  parameter int WORD_BITS = rbi_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [rbi_pkg::IN_DATA_BITS-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // point_x, point_y, point_z (32 bits each)
  output logic [rbi_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // hit (1 bit), hit_plane (2 bits)
  output logic [rbi_pkg::OUT_USER_BITS-1:0] out_tuser
);

  localparam int ITEM_BITS = rbi_pkg::item_bits(WORD_BITS);

  // classified item at the fifo input and output
  logic [ITEM_BITS-1:0] cls_data;
  logic [ITEM_BITS-1:0] q_data;
  logic                 q_valid;
  logic                 q_pop;

  // classify straight from the input bus
  rbi_front #(
    .WORD_BITS (WORD_BITS),
    .ITEM_BITS (ITEM_BITS)
  ) u_front (
    .in_tdata  (in_tdata),
    .item_data (cls_data)
  );

  // an input transfer is a fifo push
  rbi_queue #(
    .DATA_BITS (ITEM_BITS),
    .DEPTH     (rbi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (cls_data),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  // divider, plane choice, products, bounds check, output register
  rbi_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ITEM_BITS (ITEM_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/rbi_front.sv =====
// front end: unpacks an item and classifies the origin against each slab
module rbi_front #(
  parameter int WORD_BITS = rbi_pkg::WORD_BITS_DEF,
  parameter int ITEM_BITS = rbi_pkg::item_bits(WORD_BITS)
) (
  input  logic [rbi_pkg::IN_DATA_BITS-1:0] in_tdata,
  output logic [ITEM_BITS-1:0]             item_data
);

  localparam int W = WORD_BITS;

  typedef struct packed {
    logic signed [W-1:0] bmin;
    logic signed [W-1:0] bmax;
    logic signed [W-1:0] org;
    logic signed [W-1:0] dir;
    logic [W-1:0]        num;
    logic [W-1:0]        dmag;
    rbi_pkg::rbi_side_t  side;
  } axis_t;

  typedef struct packed {
    axis_t [2:0] ax;
    logic        org_in;
  } item_t;

  item_t item;

  function automatic logic signed [W-1:0] load_word(input logic [rbi_pkg::FIELD_BITS-1:0] x);
    logic signed [rbi_pkg::EXT_BITS-1:0] e;
    e = rbi_pkg::EXT_BITS'(signed'(x));
    return e[W-1:0];
  endfunction

  always_comb begin
    logic signed [W-1:0] bmin, bmax, org, dir;
    logic                out_any;
    out_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      bmin = load_word(in_tdata[rbi_pkg::FIELD_BITS*a +: rbi_pkg::FIELD_BITS]);
      bmax = load_word(in_tdata[rbi_pkg::FIELD_BITS*(3+a) +: rbi_pkg::FIELD_BITS]);
      org  = load_word(in_tdata[rbi_pkg::FIELD_BITS*(6+a) +: rbi_pkg::FIELD_BITS]);
      dir  = load_word(in_tdata[rbi_pkg::FIELD_BITS*(9+a) +: rbi_pkg::FIELD_BITS]);
      item.ax[a].bmin       = bmin;
      item.ax[a].bmax       = bmax;
      item.ax[a].org        = org;
      item.ax[a].dir        = dir;
      item.ax[a].side.below = org < bmin;
      item.ax[a].side.above = !(org < bmin) && (org > bmax);
      // distance to the candidate face, nonnegative when the origin lies outside the slab
      item.ax[a].num  = (org < bmin) ? W'(bmin - org) : W'(org - bmax);
      item.ax[a].dmag = dir[W-1] ? W'(-dir) : W'(dir);
      out_any = out_any | item.ax[a].side.below | item.ax[a].side.above;
    end
    item.org_in = !out_any;
  end

  assign item_data = ITEM_BITS'(item);

endmodule

// ===== rtl/rbi_queue.sv =====
// short fifo between the classifying front end and the arithmetic back end
module rbi_queue #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH     = rbi_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 rd_valid,
  input  logic                 rd_pop,
  output logic [DATA_BITS-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [PW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 push, pop;

  assign wr_ready = count_r != CW'(DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/rbi_back.sv =====
// back end: pipelined slab division, plane choice, products and bounds checks
module rbi_back #(
  parameter int WORD_BITS = rbi_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF,
  parameter int ITEM_BITS = rbi_pkg::item_bits(WORD_BITS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [ITEM_BITS-1:0]              q_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rbi_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic [rbi_pkg::OUT_USER_BITS-1:0] out_tuser
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QB = W + F;
  localparam int TW = W + F + 1;
  localparam int DB = rbi_pkg::MUL_DIGIT;
  localparam int ND = (W + DB - 1) / DB;
  localparam int MW = ND * DB;
  localparam int FB = rbi_pkg::FIELD_BITS;

  typedef struct packed {
    logic signed [W-1:0] bmin;
    logic signed [W-1:0] bmax;
    logic signed [W-1:0] org;
    logic signed [W-1:0] dir;
    logic [W-1:0]        num;
    logic [W-1:0]        dmag;
    rbi_pkg::rbi_side_t  side;
  } axis_t;

  typedef struct packed {
    axis_t [2:0] ax;
    logic        org_in;
  } item_t;

  function automatic logic [FB-1:0] to_field(input logic signed [W-1:0] v);
    logic signed [rbi_pkg::EXT_BITS-1:0] e;
    e = rbi_pkg::EXT_BITS'(v);
    return e[FB-1:0];
  endfunction

  logic en;

  // division pipeline, entry 0 holds the item just popped
  item_t         d_item_r [QB+1];
  logic [QB:0]   d_v_r;
  logic [W-1:0]  d_rem_r  [QB+1][3];
  logic [QB-1:0] d_quo_r  [QB+1][3];
  logic [W-1:0]  d_rem_nxt [QB][3];
  logic [QB-1:0] d_quo_nxt [QB][3];

  logic signed [TW-1:0] t1_t_r [3];
  item_t                t1_item_r;
  logic                 t1_v_r;

  rbi_pkg::rbi_plane_t t2_wp_r;
  logic [W-1:0]        t2_tm_r;
  logic                t2_hit0_r;
  item_t               t2_item_r;
  logic                t2_v_r;

  logic [2*DB-1:0]     m1_pp_r [3][ND][ND];
  rbi_pkg::rbi_plane_t m1_wp_r;
  logic                m1_hit0_r;
  item_t               m1_item_r;
  logic                m1_v_r;

  logic [W-1:0]        m2_ml_r  [3];
  logic                m2_ovf_r [3];
  rbi_pkg::rbi_plane_t m2_wp_r;
  logic                m2_hit0_r;
  item_t               m2_item_r;
  logic                m2_v_r;

  logic [W-1:0]        c1_cu_r  [3];
  logic                c1_bad_r [3];
  logic [W-1:0]        c1_pt_r  [3];
  rbi_pkg::rbi_plane_t c1_wp_r;
  logic                c1_hit0_r;
  item_t               c1_item_r;
  logic                c1_v_r;

  logic                out_valid_r;
  logic                out_hit_r;
  rbi_pkg::rbi_plane_t out_plane_r;
  logic [FB-1:0]       out_point_r [3];

  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && q_valid;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r       <= '0;
      t1_v_r      <= 1'b0;
      t2_v_r      <= 1'b0;
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      c1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      d_v_r       <= {d_v_r[QB-1:0], q_valid};
      t1_v_r      <= d_v_r[QB];
      t2_v_r      <= t1_v_r;
      m1_v_r      <= t2_v_r;
      m2_v_r      <= m1_v_r;
      c1_v_r      <= m2_v_r;
      out_valid_r <= c1_v_r;
    end
  end

  // one restoring quotient bit per stage and axis
  always_comb begin
    logic [W:0]    sh;
    logic [QB-1:0] dvd;
    logic [W-1:0]  rin;
    logic [QB-1:0] qin;
    for (int s = 0; s < QB; s++) begin
      for (int a = 0; a < 3; a++) begin
        dvd = {d_item_r[s].ax[a].num, {F{1'b0}}};
        rin = (s == 0) ? '0 : d_rem_r[s][a];
        qin = (s == 0) ? '0 : d_quo_r[s][a];
        sh  = {rin, dvd[QB-1-s]};
        if (sh >= {1'b0, d_item_r[s].ax[a].dmag}) begin
          d_rem_nxt[s][a] = W'(sh - {1'b0, d_item_r[s].ax[a].dmag});
          d_quo_nxt[s][a] = {qin[QB-2:0], 1'b1};
        end else begin
          d_rem_nxt[s][a] = sh[W-1:0];
          d_quo_nxt[s][a] = {qin[QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_item_r[0] <= item_t'(q_data);
      for (int a = 0; a < 3; a++) begin
        d_rem_r[0][a] <= '0;
        d_quo_r[0][a] <= '0;
      end
      for (int s = 0; s < QB; s++) begin
        d_item_r[s+1] <= d_item_r[s];
        for (int a = 0; a < 3; a++) begin
          d_rem_r[s+1][a] <= d_rem_nxt[s][a];
          d_quo_r[s+1][a] <= d_quo_nxt[s][a];
        end
      end
    end
  end

  // signed, saturated distances; axes without a candidate get minus one
  always_ff @(posedge clk) begin
    logic          neg, den, sat;
    logic [W-1:0]  half, lim, qs, tw;
    logic [QB-1:0] q;
    if (en) begin
      t1_item_r <= d_item_r[QB];
      for (int a = 0; a < 3; a++) begin
        den  = (d_item_r[QB].ax[a].side.below || d_item_r[QB].ax[a].side.above)
               && (d_item_r[QB].ax[a].dir != '0);
        neg  = d_item_r[QB].ax[a].side.below ? d_item_r[QB].ax[a].dir[W-1]
             : !d_item_r[QB].ax[a].dir[W-1] && (d_item_r[QB].ax[a].dir != '0);
        half = {1'b1, {(W-1){1'b0}}};
        lim  = neg ? half : half - 1'b1;
        q    = d_quo_r[QB][a];
        sat  = q > {{F{1'b0}}, lim};
        qs   = sat ? lim : q[W-1:0];
        tw   = neg ? W'(-qs) : qs;
        t1_t_r[a] <= den ? TW'($signed(tw)) : TW'(-(TW'(1) << F));
      end
    end
  end

  // largest distance picks the plane, ties keep the lower axis
  always_ff @(posedge clk) begin
    rbi_pkg::rbi_plane_t  wp;
    logic signed [TW-1:0] tb;
    if (en) begin
      wp = rbi_pkg::PLANE_X;
      tb = t1_t_r[0];
      if (t1_t_r[0] < t1_t_r[1]) begin
        wp = rbi_pkg::PLANE_Y;
        tb = t1_t_r[1];
      end
      if (tb < t1_t_r[2]) begin
        wp = rbi_pkg::PLANE_Z;
        tb = t1_t_r[2];
      end
      t2_wp_r   <= wp;
      t2_tm_r   <= tb[W-1:0];
      t2_hit0_r <= !tb[TW-1];
      t2_item_r <= t1_item_r;
    end
  end

  // partial products of t * |dir| in digits of at most 32 bits
  always_ff @(posedge clk) begin
    logic [MW-1:0] ap, bp;
    if (en) begin
      ap = MW'(t2_tm_r);
      for (int a = 0; a < 3; a++) begin
        bp = MW'(t2_item_r.ax[a].dmag);
        for (int i = 0; i < ND; i++) begin
          for (int j = 0; j < ND; j++) begin
            m1_pp_r[a][i][j] <= ap[DB*i +: DB] * bp[DB*j +: DB];
          end
        end
      end
      m1_wp_r   <= t2_wp_r;
      m1_hit0_r <= t2_hit0_r;
      m1_item_r <= t2_item_r;
    end
  end

  // sum the digits and drop the fraction; anything beyond the word flags the coordinate as out of range
  always_ff @(posedge clk) begin
    logic [2*MW-1:0] acc;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        acc = '0;
        for (int i = 0; i < ND; i++) begin
          for (int j = 0; j < ND; j++) begin
            acc = acc + ((2*MW)'(m1_pp_r[a][i][j]) << (DB * (i + j)));
          end
        end
        m2_ml_r[a]  <= acc[W+F-1:F];
        m2_ovf_r[a] <= |acc[2*MW-1:W+F];
      end
      m2_wp_r   <= m1_wp_r;
      m2_hit0_r <= m1_hit0_r;
      m2_item_r <= m1_item_r;
    end
  end

  // coordinate in offset binary with range check, and its two's complement form
  always_ff @(posedge clk) begin
    logic [W-1:0] ou, ml, cu;
    logic [W:0]   sum;
    logic         bad;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ou  = {~m2_item_r.ax[a].org[W-1], m2_item_r.ax[a].org[W-2:0]};
        ml  = m2_ml_r[a];
        sum = {1'b0, ou} + {1'b0, ml};
        if (m2_item_r.ax[a].dir[W-1]) begin
          bad = ml > ou;
          cu  = ou - ml;
        end else begin
          bad = sum[W];
          cu  = sum[W-1:0];
        end
        c1_cu_r[a]  <= cu;
        c1_bad_r[a] <= bad || m2_ovf_r[a];
        c1_pt_r[a]  <= m2_item_r.ax[a].dir[W-1] ? W'(m2_item_r.ax[a].org - ml)
                                                 : W'(m2_item_r.ax[a].org + ml);
      end
      c1_wp_r   <= m2_wp_r;
      c1_hit0_r <= m2_hit0_r;
      c1_item_r <= m2_item_r;
    end
  end

  // bounds check and result assembly into the output register
  always_ff @(posedge clk) begin
    logic [W-1:0]        lo, hi;
    logic                ok, hit;
    logic signed [W-1:0] pv [3];
    if (en) begin
      ok = c1_hit0_r;
      for (int a = 0; a < 3; a++) begin
        lo = {~c1_item_r.ax[a].bmin[W-1], c1_item_r.ax[a].bmin[W-2:0]};
        hi = {~c1_item_r.ax[a].bmax[W-1], c1_item_r.ax[a].bmax[W-2:0]};
        if (2'(a) == c1_wp_r) begin
          pv[a] = c1_item_r.ax[a].side.below ? c1_item_r.ax[a].bmin
                                             : c1_item_r.ax[a].bmax;
        end else begin
          pv[a] = c1_pt_r[a];
          if (c1_bad_r[a] || (c1_cu_r[a] < lo) || (c1_cu_r[a] > hi)) begin
            ok = 1'b0;
          end
        end
      end
      hit = c1_item_r.org_in || ok;
      out_hit_r <= hit;
      if (c1_item_r.org_in) begin
        out_plane_r <= rbi_pkg::PLANE_ORIGIN;
      end else if (hit) begin
        out_plane_r <= c1_wp_r;
      end else begin
        out_plane_r <= rbi_pkg::PLANE_X;
      end
      for (int a = 0; a < 3; a++) begin
        if (c1_item_r.org_in) begin
          out_point_r[a] <= to_field(c1_item_r.ax[a].org);
        end else if (hit) begin
          out_point_r[a] <= to_field(pv[a]);
        end else begin
          out_point_r[a] <= '0;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_point_r[2], out_point_r[1], out_point_r[0]};
  assign out_tuser  = {out_plane_r, out_hit_r};

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |->
      out_point_r[0] == '0 && out_point_r[1] == '0 && out_point_r[2] == '0
      && out_plane_r == rbi_pkg::PLANE_X)
    else $error("miss result carries a nonzero point or plane");

  a_origin_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_plane_r == rbi_pkg::PLANE_ORIGIN |-> out_hit_r)
    else $error("origin plane reported without a hit");

  a_inside_path: assert property (@(posedge clk) disable iff (!rst_n)
    en && c1_v_r && c1_item_r.org_in |=>
      out_valid_r && out_hit_r && out_plane_r == rbi_pkg::PLANE_ORIGIN)
    else $error("inside item lost its origin hit");
`endif

endmodule
